@@ rtl/sag_drive_valve_shaper_core_assert.svh @@
// assertion macros for the valve shaper checker
// no dependencies; taken in by the checker file
`ifndef SAG_DRIVE_VALVE_SHAPER_CORE_ASSERT_SVH
`define SAG_DRIVE_VALVE_SHAPER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define SDVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdvs: same-cycle check failed");

// next-cycle implication, off while reset is low
`define SDVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdvs: next-cycle check failed");

// next-cycle implication that also watches reset itself
`define SDVS_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sdvs: reset check failed");

`endif

@@ rtl/sdvs_pkg.sv @@
// shared types, constants and tables of the valve shaper
// used by the front, queue, back and top-level rtl files; depends on nothing
package sdvs_pkg;

    // sizes
    localparam int CHANNELS_DEF = 2;
    localparam int TANH_ENTRIES = 256;              // power of two
    localparam int TANH_LOG2    = $clog2(TANH_ENTRIES);
    localparam int TAB_W        = 15;
    localparam int SAMPLE_W     = 16;
    localparam int ENV_W        = 24;
    localparam int GAIN_W       = 16;
    localparam int COEF_W       = 24;
    localparam int DRV_W        = 24;
    localparam int MAG_W        = 17;
    localparam int T_W          = 26;
    localparam int SCALE_W      = 20;
    localparam int U_W          = 30;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int QUEUE_DEPTH  = 2;                // power of two

    // register indexes of the config port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DRIVE_GAIN    = 3'd0,
        REG_BIAS_OFFSET   = 3'd1,
        REG_SAG_DEPTH     = 3'd2,
        REG_ATTACK_COEFF  = 3'd3,
        REG_RELEASE_COEFF = 3'd4,
        REG_VALVE_MODE    = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_TRIODE  = 2'd0,
        MODE_PENTODE = 2'd1,
        MODE_TORTURE = 2'd2,
        MODE_DEFAULT = 2'd3
    } t_valve_mode;

    typedef struct packed {
        logic [GAIN_W-1:0]          drive_gain;
        logic signed [SAMPLE_W-1:0] bias_offset;
        logic [GAIN_W-1:0]          sag_depth;
        logic [COEF_W-1:0]          attack_coeff;
        logic [COEF_W-1:0]          release_coeff;
        t_valve_mode                valve_mode;
    } t_cfg;

    // one item between front and back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       chan;
        logic [DRV_W-1:0]           drv;
    } t_qitem;

    typedef struct packed {
        logic   push;
        t_qitem item;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // curvature * (1 + asymmetry), Q.16
    function automatic logic [SCALE_W-1:0] scale_pos(input t_valve_mode m);
        logic [SCALE_W-1:0] r;
        case (m)
            MODE_TRIODE:  r = 20'd245760;
            MODE_PENTODE: r = 20'd484966;
            MODE_TORTURE: r = 20'd891290;
            default:      r = 20'd393216;
        endcase
        return r;
    endfunction

    // curvature * (1 - asymmetry), Q.16
    function automatic logic [SCALE_W-1:0] scale_neg(input t_valve_mode m);
        logic [SCALE_W-1:0] r;
        case (m)
            MODE_TRIODE:  r = 20'd81920;
            MODE_PENTODE: r = 20'd39322;
            MODE_TORTURE: r = 20'd157286;
            default:      r = 20'd131072;
        endcase
        return r;
    endfunction

    // shift and subtract quotient of non-negative values, table build only
    function automatic longint udiv(input longint dividend, input longint divisor);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((dividend >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= divisor) begin
                r = r - divisor;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // tanh points over [0, 8), one past the end for interpolation
    typedef logic [TAB_W-1:0] t_tanh_tab [0:TANH_ENTRIES];

    function automatic t_tanh_tab build_tanh_tab();
        t_tanh_tab tab;
        longint    q30;
        longint    prev;
        longint    a;
        longint    s;
        longint    s2;
        longint    s3;
        longint    s4;
        longint    e;
        longint    num;
        longint    den;
        longint    v;
        int        i;
        int        k;
        q30  = 64'sd1 <<< 30;
        prev = 0;
        for (i = 0; i <= TANH_ENTRIES; i++) begin
            a  = (longint'(i) * (64'sd1 <<< 19) + TANH_ENTRIES / 2) / TANH_ENTRIES;
            s  = (2 * a) <<< 4;
            s2 = (s * s + (64'sd1 <<< 29)) >>> 30;
            s3 = (s2 * s + (64'sd1 <<< 29)) >>> 30;
            s4 = (s3 * s + (64'sd1 <<< 29)) >>> 30;
            // e^(-2a/1024) by series, then squared up to e^(-2a)
            e  = q30 - s + s2 / 2 - udiv(s3, 64'sd6) + udiv(s4, 64'sd24);
            for (k = 0; k < 10; k++) begin
                e = (e * e + (64'sd1 <<< 29)) >>> 30;
            end
            if (e < 0) e = 0;
            if (e > q30) e = q30;
            num = (q30 - e) * 32768;
            den = q30 + e;
            v   = udiv(num + den / 2, den);
            if (v > 32767) v = 32767;
            if (v < prev) v = prev;
            tab[i] = TAB_W'(v);
            prev   = v;
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh_tab();

endpackage

@@ rtl/sdvs_front.sv @@
// front of the valve shaper: takes a sample, updates its channel envelope,
// works out the sagged drive and hands the item to the queue; uses sdvs_pkg
module sdvs_front #(
    parameter int CHANNELS = sdvs_pkg::CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdvs_pkg::t_cfg                       i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [sdvs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_chan,
    output sdvs_pkg::t_q_wr                      o_wr,
    input  logic                                 i_q_full
);

    localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENV_W     = sdvs_pkg::ENV_W;
    localparam int ENV_PW    = ENV_W + sdvs_pkg::COEF_W;
    localparam int SAG_PW    = sdvs_pkg::GAIN_W + ENV_W;
    localparam int DRV_PW    = sdvs_pkg::GAIN_W + ENV_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ENV,
        F_FAC,
        F_DRV
    } t_fstate;

    t_fstate                             r_state;
    logic [ENV_W-1:0]                    r_env [CHANNELS];
    logic signed [sdvs_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_chan;
    logic [CH_IW-1:0]                    r_ch;
    logic                                r_rising;
    logic [ENV_W-1:0]                    r_d;
    logic [sdvs_pkg::COEF_W-1:0]         r_coef;
    logic [ENV_W-1:0]                    r_env_old;
    logic [ENV_W-1:0]                    r_env_new;
    logic [ENV_W-1:0]                    r_fac;

    logic [CH_IW-1:0]                    ch_in;
    logic [sdvs_pkg::SAMPLE_W-1:0]       mag;
    logic [ENV_W-1:0]                    rect;
    logic [ENV_W-1:0]                    env_cur;
    logic                                rising;
    logic [ENV_PW-1:0]                   env_sum;
    logic [ENV_W-1:0]                    delta;
    logic [ENV_W-1:0]                    n_env;
    logic [SAG_PW-1:0]                   sag_prod;
    logic [SAG_PW-1:0]                   fac_raw;
    logic [ENV_W-1:0]                    n_fac;
    logic [DRV_PW-1:0]                   drv_sum;
    logic [sdvs_pkg::DRV_W-1:0]          n_drv;

    assign o_in_ready = (r_state == F_IDLE);

    // channel index wraps onto the envelope store
    assign ch_in = (CHANNELS > 1) ? CH_IW'(i_chan) : '0;

    // rectify and compare against the stored envelope
    always_comb begin
        mag     = i_sample[sdvs_pkg::SAMPLE_W-1] ? (16'd0 - $unsigned(i_sample))
                                                 : $unsigned(i_sample);
        rect    = {mag, 8'h00};
        env_cur = r_env[ch_in];
        rising  = rect > env_cur;
    end

    // envelope step: move toward the rectified input by a rounded fraction
    always_comb begin
        env_sum = ENV_PW'(r_coef) * ENV_PW'(r_d) + ENV_PW'(24'h800000);
        delta   = env_sum[ENV_PW-1:sdvs_pkg::COEF_W];
        n_env   = r_rising ? (r_env_old + delta) : (r_env_old - delta);
    end

    // sag factor, Q1.23
    always_comb begin
        sag_prod = SAG_PW'(i_cfg.sag_depth) * SAG_PW'(r_env_new);
        fac_raw  = (SAG_PW'(1) << (SAG_PW - 1)) - sag_prod + SAG_PW'(17'h08000);
        n_fac    = fac_raw[SAG_PW-1:16];
    end

    // drive gain times sag factor
    always_comb begin
        drv_sum = DRV_PW'(i_cfg.drive_gain) * DRV_PW'(r_fac) + DRV_PW'(15'h4000);
        n_drv   = drv_sum[sdvs_pkg::DRV_W+14:15];
    end

    // queue write
    always_comb begin
        o_wr.push        = (r_state == F_DRV) && !i_q_full;
        o_wr.item.sample = r_sample;
        o_wr.item.chan   = r_chan;
        o_wr.item.drv    = n_drv;
    end

    // sequencer with envelope store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                r_env[i] <= '0;
            end
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_sample  <= i_sample;
                        r_chan    <= i_chan;
                        r_ch      <= ch_in;
                        r_rising  <= rising;
                        r_d       <= rising ? (rect - env_cur) : (env_cur - rect);
                        r_coef    <= rising ? i_cfg.attack_coeff : i_cfg.release_coeff;
                        r_env_old <= env_cur;
                        r_state   <= F_ENV;
                    end
                end
                F_ENV: begin
                    r_env[r_ch] <= n_env;
                    r_env_new   <= n_env;
                    r_state     <= F_FAC;
                end
                F_FAC: begin
                    r_fac   <= n_fac;
                    r_state <= F_DRV;
                end
                F_DRV: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/sdvs_queue.sv @@
// short queue between front and back of the valve shaper
// holds items of type sdvs_pkg::t_qitem; uses sdvs_pkg
module sdvs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdvs_pkg::t_q_wr   i_wr,
    input  logic              i_pop,
    output sdvs_pkg::t_qitem  o_head,
    output sdvs_pkg::t_q_stat o_stat
);

    localparam int DEPTH = sdvs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    sdvs_pkg::t_qitem r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_wr.push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.item;
        end
    end

endmodule

@@ rtl/sdvs_back.sv @@
// back of the valve shaper: bias, drive, mode scale, tanh lookup and
// interpolation, plus the output register; uses sdvs_pkg
module sdvs_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdvs_pkg::t_cfg                       i_cfg,
    input  sdvs_pkg::t_qitem                     i_head,
    input  sdvs_pkg::t_q_stat                    i_stat,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [sdvs_pkg::SAMPLE_W-1:0] o_shaped,
    output logic                                 o_chan
);

    localparam int SW     = sdvs_pkg::SAMPLE_W;
    localparam int MAG_W  = sdvs_pkg::MAG_W;
    localparam int T_W    = sdvs_pkg::T_W;
    localparam int U_W    = sdvs_pkg::U_W;
    localparam int TAB_W  = sdvs_pkg::TAB_W;
    localparam int LOG2   = sdvs_pkg::TANH_LOG2;
    localparam int T_PW   = MAG_W + sdvs_pkg::DRV_W;
    localparam int U_PW   = T_W + sdvs_pkg::SCALE_W;
    localparam int P_W    = U_W + LOG2;
    localparam int IDX_W  = P_W - 19;
    localparam int I_PW   = TAB_W + 16;

    typedef enum logic [1:0] {
        B_IDLE,
        B_U,
        B_LOOK,
        B_INTERP
    } t_bstate;

    t_bstate                 r_state;
    logic                    r_neg;
    logic                    r_chan;
    logic [T_W-1:0]          r_t;
    logic [U_W-1:0]          r_u;
    logic                    r_oor;
    logic [TAB_W-1:0]        r_lo;
    logic [TAB_W-1:0]        r_diff;
    logic [15:0]             r_frac;
    logic                    r_out_valid;
    logic [SW-1:0]           r_out_data;
    logic                    r_out_chan;

    logic signed [MAG_W-1:0] x;
    logic                    neg;
    logic [MAG_W-1:0]        mx;
    logic [T_PW-1:0]         t_sum;
    logic [sdvs_pkg::SCALE_W-1:0] scale;
    logic [U_PW-1:0]         u_sum;
    logic [P_W-1:0]          p;
    logic [IDX_W-1:0]        idx;
    logic [LOG2:0]           lo_addr;
    logic [LOG2:0]           hi_addr;
    logic [TAB_W-1:0]        tab_lo;
    logic [TAB_W-1:0]        tab_hi;
    logic [I_PW-1:0]         i_sum;
    logic [SW-1:0]           y;
    logic [SW-1:0]           mag_out;
    logic                    out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == B_IDLE) && !i_stat.empty;
    assign o_out_valid = r_out_valid;
    assign o_shaped    = $signed(r_out_data);
    assign o_chan      = r_out_chan;

    // biased sample, magnitude times drive
    always_comb begin
        x     = $signed({i_head.sample[SW-1], i_head.sample})
              + $signed({i_cfg.bias_offset[SW-1], i_cfg.bias_offset});
        neg   = x[MAG_W-1];
        mx    = neg ? (17'd0 - $unsigned(x)) : $unsigned(x);
        t_sum = T_PW'(mx) * T_PW'(i_head.drv) + T_PW'(15'h4000);
    end

    // mode scale, sign picks the curve half
    always_comb begin
        scale = r_neg ? sdvs_pkg::scale_neg(i_cfg.valve_mode)
                      : sdvs_pkg::scale_pos(i_cfg.valve_mode);
        u_sum = U_PW'(r_t) * U_PW'(scale) + U_PW'(16'h8000);
    end

    // table position and neighbours
    always_comb begin
        p       = {r_u, LOG2'(0)};
        idx     = p[P_W-1:19];
        lo_addr = {1'b0, idx[LOG2-1:0]};
        hi_addr = lo_addr + 1'b1;
        tab_lo  = sdvs_pkg::TANH_TAB[lo_addr];
        tab_hi  = sdvs_pkg::TANH_TAB[hi_addr];
    end

    // interpolation and saturation; the sign goes on in the output register
    always_comb begin
        i_sum   = I_PW'(r_diff) * I_PW'(r_frac) + I_PW'(16'h8000);
        y       = SW'(r_lo) + SW'(i_sum[I_PW-1:16]);
        if (r_oor || (y > 16'd32767)) begin
            mag_out = 16'd32767;
        end else begin
            mag_out = y;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result beat loads on the last step, clears once taken
            if ((r_state == B_INTERP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_stat.empty) begin
                        r_neg   <= neg;
                        r_chan  <= i_head.chan;
                        r_t     <= t_sum[T_W+14:15];
                        r_state <= B_U;
                    end
                end
                B_U: begin
                    r_u     <= u_sum[U_W+15:16];
                    r_state <= B_LOOK;
                end
                B_LOOK: begin
                    r_oor   <= |idx[IDX_W-1:LOG2];
                    r_lo    <= tab_lo;
                    r_diff  <= tab_hi - tab_lo;
                    r_frac  <= p[18:3];
                    r_state <= B_INTERP;
                end
                B_INTERP: begin
                    if (out_free) begin
                        r_out_data  <= r_neg ? (16'd0 - mag_out) : mag_out;
                        r_out_chan  <= r_chan;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/sag_drive_valve_shaper_core.sv @@
// top level of the sag-drive valve shaper: config registers and the
// front / queue / back chain; uses sdvs_pkg, sdvs_front, sdvs_queue, sdvs_back
//
//  channel   direction  beat payload
//  s_axis    in         tdata: sample_in[15:0]   tuser: chan_in
//  m_axis    out        tdata: shaped_out[15:0]  tuser: chan_out
//  cfg       in         i_cfg_we, i_cfg_addr (register index), i_cfg_wdata
//
// s_axis takes one beat at a time: the front accepts it, then runs
// envelope, sag factor and drive steps, one multiply each, before the next.
// the back takes each item through drive, mode scale, table read and
// interpolation steps, then into the output register that drives m_axis.
// synchronous active-low reset clears envelopes and handshake state and loads config defaults.
// a stalled m_axis holds the back in its last step, the queue fills and
// the front waits in its drive step with s_axis_tready low.
module sag_drive_valve_shaper_core #(
    parameter int CHANNELS = sdvs_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
    input  logic                              s_axis_tuser,   // [0] chan_in
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [15:0] shaped_out
    output logic                              m_axis_tuser,   // [0] chan_out
    // config write port
    input  logic                              i_cfg_we,
    input  logic [sdvs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sdvs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    sdvs_pkg::t_cfg    r_cfg;
    sdvs_pkg::t_q_wr   q_wr;
    sdvs_pkg::t_q_stat q_stat;
    sdvs_pkg::t_qitem  q_head;
    logic              q_pop;
    logic signed [15:0] shaped;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_gain    <= 16'd256;
            r_cfg.bias_offset   <= 16'sd0;
            r_cfg.sag_depth     <= 16'd0;
            r_cfg.attack_coeff  <= 24'd10918;
            r_cfg.release_coeff <= 24'd437;
            r_cfg.valve_mode    <= sdvs_pkg::MODE_TRIODE;
        end else if (i_cfg_we) begin
            case (sdvs_pkg::t_cfg_reg'(i_cfg_addr))
                sdvs_pkg::REG_DRIVE_GAIN:    r_cfg.drive_gain    <= i_cfg_wdata[15:0];
                sdvs_pkg::REG_BIAS_OFFSET:   r_cfg.bias_offset   <= $signed(i_cfg_wdata[15:0]);
                sdvs_pkg::REG_SAG_DEPTH:     r_cfg.sag_depth     <= i_cfg_wdata[15:0];
                sdvs_pkg::REG_ATTACK_COEFF:  r_cfg.attack_coeff  <= i_cfg_wdata;
                sdvs_pkg::REG_RELEASE_COEFF: r_cfg.release_coeff <= i_cfg_wdata;
                sdvs_pkg::REG_VALVE_MODE:
                    r_cfg.valve_mode <= sdvs_pkg::t_valve_mode'(i_cfg_wdata[1:0]);
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // envelope and drive
    sdvs_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sample   ($signed(s_axis_tdata)),
        .i_chan     (s_axis_tuser),
        .o_wr       (q_wr),
        .i_q_full   (q_stat.full)
    );

    // decoupling queue
    sdvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // shaping and output register
    sdvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .i_stat      (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_shaped    (shaped),
        .o_chan      (m_axis_tuser)
    );

    assign m_axis_tdata = $unsigned(shaped);

endmodule

@@ rtl/sdvs_port_checker.sv @@
// port-level checks of the valve shaper, bound to the top level
// uses the macros of sag_drive_valve_shaper_core_assert.svh
`include "sag_drive_valve_shaper_core_assert.svh"

module sdvs_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result beat keeps its payload
    `SDVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // the shaper saturates symmetrically, so the most negative code never shows
    `SDVS_ASSERT_IMP(a_out_symmetric, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata != 16'h8000)

    // the front is busy for the envelope steps after each input beat
    `SDVS_ASSERT_NEXT(a_in_spacing, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no result right after reset
    `SDVS_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind sag_drive_valve_shaper_core sdvs_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
